// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the parser rtl
// expects clk_i and rst_ni in the scope that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define XCFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("xcfp assertion failed");

// condition must never be true out of reset
`define XCFP_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("xcfp forbidden condition seen");

`endif

// ===== rtl/core/xcfp_pkg.sv =====
// types and constants of the xor checked frame parser
// no dependencies
package xcfp_pkg;

  localparam logic [15:0] FrameOverhead = 16'd6;
  localparam logic [15:0] MaxPayloadRst = 16'd65529;

  // status codes
  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StSum    = 2'd1;
  localparam logic [1:0] StType   = 2'd2;
  localparam logic [1:0] StLength = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CfgStartTag   = 2'd0;
  localparam logic [1:0] CfgFrameType  = 2'd1;
  localparam logic [1:0] CfgMaxPayload = 2'd2;

  typedef struct packed {
    logic [7:0]  start_tag;
    logic [7:0]  frame_type;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic [15:0] payload_len;
    logic        last;
  } res_t;

endpackage

// ===== rtl/core/xcfp_if.sv =====
// valid/ready channel interfaces of the parser: byte input and result output
// no dependencies
interface xcfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface xcfp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic [1:0]  status;
  logic [15:0] payload_len;
  logic        last;

  modport source (output valid, output kind, output out_byte, output status,
                  output payload_len, output last, input ready);
  modport sink (input valid, input kind, input out_byte, input status,
                input payload_len, input last, output ready);
endinterface

// ===== rtl/core/xcfp_core.sv =====
// frame state machine: phase, running xor, length and payload count
// depends on xcfp_pkg and assert_macros.svh
`include "assert_macros.svh"

module xcfp_core
  import xcfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  typedef enum logic [2:0] {
    PhHunt, PhCheck, PhType, PhLenHi, PhLenLo, PhPayload, PhEnd
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  check_q, check_d;
  logic [15:0] len_q, len_d;
  logic [15:0] count_q, count_d;

  logic [15:0] len_full;
  logic [15:0] plen_full;
  logic [15:0] plen_cur;
  logic [15:0] count_inc;
  logic [7:0]  xor_fin;
  logic        res_valid;
  res_t        res;

  assign len_full  = {len_q[15:8], byte_i};
  assign plen_full = len_full - FrameOverhead;
  assign plen_cur  = len_q - FrameOverhead;
  assign count_inc = count_q + 16'd1;
  assign xor_fin   = xor_q ^ byte_i;

  always_comb begin
    phase_d   = phase_q;
    xor_d     = xor_q;
    check_d   = check_q;
    len_d     = len_q;
    count_d   = count_q;
    res_valid = 1'b0;
    res       = '0;
    case (phase_q)
      PhCheck: begin
        // checksum byte counts as zero in the xor
        check_d = byte_i;
        phase_d = PhType;
      end
      PhType: begin
        if (byte_i != cfg_i.frame_type) begin
          phase_d    = PhHunt;
          res_valid  = 1'b1;
          res.kind   = 1'b1;
          res.status = StType;
          res.last   = 1'b1;
        end else begin
          xor_d   = xor_fin;
          phase_d = PhLenHi;
        end
      end
      PhLenHi: begin
        xor_d   = xor_fin;
        len_d   = {byte_i, 8'd0};
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        xor_d = xor_fin;
        len_d = len_full;
        if (len_full < FrameOverhead) begin
          phase_d    = PhHunt;
          res_valid  = 1'b1;
          res.kind   = 1'b1;
          res.status = StLength;
          res.last   = 1'b1;
        end else if (plen_full > cfg_i.max_payload) begin
          phase_d         = PhHunt;
          res_valid       = 1'b1;
          res.kind        = 1'b1;
          res.status      = StLength;
          res.payload_len = plen_full;
          res.last        = 1'b1;
        end else begin
          count_d = '0;
          phase_d = (plen_full == 16'd0) ? PhEnd : PhPayload;
        end
      end
      PhPayload: begin
        xor_d     = xor_fin;
        count_d   = count_inc;
        if (count_inc >= plen_cur) begin
          phase_d = PhEnd;
        end
        res_valid    = 1'b1;
        res.out_byte = byte_i;
      end
      PhEnd: begin
        // end byte value itself is not checked
        xor_d           = xor_fin;
        phase_d         = PhHunt;
        res_valid       = 1'b1;
        res.kind        = 1'b1;
        res.status      = (xor_fin == check_q) ? StOk : StSum;
        res.payload_len = plen_cur;
        res.last        = 1'b1;
      end
      default: begin
        if (byte_i == cfg_i.start_tag) begin
          xor_d   = byte_i;
          check_d = '0;
          len_d   = '0;
          count_d = '0;
          phase_d = PhCheck;
        end else begin
          phase_d = PhHunt;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      xor_q   <= '0;
      check_q <= '0;
      len_q   <= '0;
      count_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      xor_q   <= xor_d;
      check_q <= check_d;
      len_q   <= len_d;
      count_q <= count_d;
    end
  end

  assign res_valid_o = step_i && res_valid;
  assign res_o       = res;

  `XCFP_ASSERT(a_last_returns_to_hunt, res_valid_o && res_o.last |=> phase_q == PhHunt)
  `XCFP_ASSERT(a_count_below_len, phase_q == PhPayload |-> count_q < plen_cur)
  `XCFP_NEVER(a_payload_without_length, phase_q == PhPayload && len_q <= FrameOverhead)

endmodule

// ===== rtl/core/xor_checked_frame_parser.sv =====
// top level of the xor checked frame parser: input stage, config, result register
// depends on xcfp_pkg, xcfp_if, xcfp_core and assert_macros.svh
//
// channel  dir  payload                                   transfer
// in_i     in   in_byte                                   valid && ready
// out_o    out  kind, out_byte, status, payload_len, last  valid && ready
// cfg      in   cfg_idx_i, cfg_data_i                     cfg_we_i
//
// one byte per cycle sustained unless the output stalls; each byte waits in the input
// register and its result (if any) then sits in the output register
// an input transfer loads the input register; the output register loads when it steps
// the input stage advances when the output register is empty or being drained
// rst_ni clears phase, running xor, counts, valid flags, start_tag and frame_type
`include "assert_macros.svh"

module xor_checked_frame_parser
  import xcfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  xcfp_in_if.sink     in_i,
  xcfp_out_if.source  out_o
);

  cfg_t       cfg_q;
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       out_valid_q;
  res_t       out_q;

  logic       step;
  logic       res_valid;
  res_t       res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_tag   <= '0;
      cfg_q.frame_type  <= '0;
      cfg_q.max_payload <= MaxPayloadRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStartTag:   cfg_q.start_tag   <= cfg_data_i[7:0];
        CfgFrameType:  cfg_q.frame_type  <= cfg_data_i[7:0];
        CfgMaxPayload: cfg_q.max_payload <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // byte in the input register is processed once the result slot is free
  assign step        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.in_byte;
    end
  end

  xcfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (s1_byte_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= res_valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.out_byte    = out_q.out_byte;
  assign out_o.status      = out_q.status;
  assign out_o.payload_len = out_q.payload_len;
  assign out_o.last        = out_q.last;

  `XCFP_NEVER(a_step_overwrites_result, res_valid && out_valid_q && !out_o.ready)
  `XCFP_ASSERT(a_payload_fields_clear, out_valid_q && !out_q.kind |-> !out_q.last && out_q.status == StOk)
  `XCFP_ASSERT(a_held_byte_blocks_input, s1_valid_q && !step |-> !in_i.ready)

endmodule
